>>> hw/rtl/apsp_pkg.sv
package apsp_pkg;

  localparam int DEFAULT_MAX_VERTICES = 16;

  localparam int OP_W     = 2;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 4;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 20;
  localparam int VC_W     = 5;

  localparam logic [VC_W-1:0]   VC_RESET = VC_W'(16);
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    logic              vld;
    logic              off_diag;
    logic [DIST_W-1:0] a;
    logic [DIST_W-1:0] b;
    logic [DIST_W-1:0] cur;
  } relax_req_t;

  typedef struct packed {
    logic              we;
    logic [DIST_W-1:0] data;
  } relax_wr_t;

endpackage

>>> hw/rtl/apsp_if.sv
interface apsp_in_if import apsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, operation, row, col, weight, input ready);
  modport sink   (input valid, operation, row, col, weight, output ready);
endinterface

interface apsp_out_if import apsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

interface apsp_cfg_if import apsp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VC_W-1:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

>>> hw/rtl/all_pairs_shortest_path_top.sv
// Channel  | Dir | Handshake            | Payload
// in_bus   | in  | valid/ready          | operation, row, col, weight
// out_bus  | out | valid/ready          | distance
// cfg_bus  | in  | valid/ready (rdy=1)  | vertex_count
//
// A run covers n = min(vertex_count, MAX_VERTICES) vertices; one row read per
// (k,i), then one (k,j)/(i,j) read pair and one write-back per cycle on the
// distance memory.
// One transaction in flight; in_bus is taken again once the result is out.
// Reset is synchronous and clears control only; the memory is not cleared.
// A stalled out_bus holds its result and blocks the next transaction.
module all_pairs_shortest_path_top import apsp_pkg::*; #(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
  input  logic      clk,
  input  logic      rst_n,
  apsp_in_if.sink   in_bus,
  apsp_out_if.source out_bus,
  apsp_cfg_if.sink  cfg_bus
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int AW = 2 * IW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_ROWA  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     k_r, k_nxt, i_r, i_nxt, j_r, j_nxt, last_r, last_nxt;
  logic [VC_W-1:0]   vc_r, vc_nxt;
  logic [DIST_W-1:0] a_r, a_nxt;
  logic              a_cap_r, a_cap_nxt;
  logic              p_vld_r, p_vld_nxt;
  logic [AW-1:0]     p_addr_r, p_addr_nxt;
  logic              p_diag_r, p_diag_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;

  logic              out_free, in_acc, in_range, run_ok;
  logic [AW-1:0]     in_addr;
  logic              we, re_a, re_b;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [DIST_W-1:0] wdata, rdata_a, rdata_b;
  relax_req_t        rreq;
  relax_wr_t         rwr;

  apsp_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  apsp_relax u_relax (
    .req (rreq),
    .wr  (rwr)
  );

  assign out_free      = !out_valid_r || out_bus.ready;
  assign in_bus.ready  = (state_r == S_IDLE) && out_free;
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid    = out_valid_r;
  assign out_bus.distance = out_dist_r;

  assign in_range = (int'(in_bus.row) < MAX_VERTICES) && (int'(in_bus.col) < MAX_VERTICES);
  assign in_addr  = {IW'(in_bus.row), IW'(in_bus.col)};
  assign run_ok   = vc_r >= VC_W'(2);

  // b = d[k][j] on port a, cur = d[i][j] on port b, a = d[i][k] held per row
  assign rreq.vld      = p_vld_r;
  assign rreq.off_diag = !p_diag_r;
  assign rreq.a        = a_r;
  assign rreq.b        = rdata_a;
  assign rreq.cur      = rdata_b;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    last_nxt      = last_r;
    vc_nxt        = vc_r;
    a_nxt         = a_cap_r ? rdata_a : a_r;
    a_cap_nxt     = 1'b0;
    p_vld_nxt     = 1'b0;
    p_addr_nxt    = p_addr_r;
    p_diag_nxt    = p_diag_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_dist_nxt  = out_dist_r;
    we            = rwr.we;
    waddr         = p_addr_r;
    wdata         = rwr.data;
    re_a          = 1'b0;
    raddr_a       = in_addr;
    re_b          = 1'b0;
    raddr_b       = {i_r, j_r};

    if (cfg_bus.valid && cfg_bus.ready) begin
      vc_nxt = cfg_bus.vertex_count;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_bus.operation)
            OP_WRITE: begin
              we            = in_range;
              waddr         = in_addr;
              wdata         = DIST_W'(in_bus.weight);
              out_valid_nxt = 1'b1;
              out_dist_nxt  = '0;
            end
            OP_RUN: begin
              if (run_ok) begin
                k_nxt     = '0;
                i_nxt     = '0;
                last_nxt  = (int'(vc_r) >= MAX_VERTICES) ? IW'(MAX_VERTICES - 1)
                                                          : IW'(vc_r - VC_W'(1));
                state_nxt = S_ROWA;
              end else begin
                out_valid_nxt = 1'b1;
                out_dist_nxt  = '0;
              end
            end
            OP_READ: begin
              re_a      = 1'b1;
              raddr_a   = in_addr;
              rd_ok_nxt = in_range;
              state_nxt = S_RD;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_dist_nxt  = '0;
            end
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = rd_ok_r ? rdata_a : '0;
          state_nxt     = S_IDLE;
        end
      end
      S_ROWA: begin
        re_a      = 1'b1;
        raddr_a   = {i_r, k_r};
        a_cap_nxt = 1'b1;
        j_nxt     = '0;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        re_a       = 1'b1;
        raddr_a    = {k_r, j_r};
        re_b       = 1'b1;
        raddr_b    = {i_r, j_r};
        p_vld_nxt  = 1'b1;
        p_addr_nxt = {i_r, j_r};
        p_diag_nxt = (i_r == j_r);
        if (j_r == last_r) begin
          if (i_r == last_r) begin
            if (k_r == last_r) begin
              state_nxt = S_DONE;
            end else begin
              k_nxt     = k_r + IW'(1);
              i_nxt     = '0;
              state_nxt = S_ROWA;
            end
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_ROWA;
          end
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= VC_RESET;
      a_cap_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      a_cap_r     <= a_cap_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    last_r     <= last_nxt;
    a_r        <= a_nxt;
    p_addr_r   <= p_addr_nxt;
    p_diag_r   <= p_diag_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_dist_r <= out_dist_nxt;
  end

endmodule

>>> hw/rtl/apsp_mem.sv
module apsp_mem import apsp_pkg::*; #(
  parameter int AW = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DIST_W-1:0] wdata,
  input  logic              re_a,
  input  logic [AW-1:0]     raddr_a,
  output logic [DIST_W-1:0] rdata_a,
  input  logic              re_b,
  input  logic [AW-1:0]     raddr_b,
  output logic [DIST_W-1:0] rdata_b
);

  localparam int DEPTH = 1 << AW;

  logic [DIST_W-1:0] mem [DEPTH];
  logic [DIST_W-1:0] rdata_a_r;
  logic [DIST_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a_r <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> hw/rtl/apsp_relax.sv
module apsp_relax import apsp_pkg::*; (
  input  relax_req_t req,
  output relax_wr_t  wr
);

  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] sat;

  assign sum = {1'b0, req.a} + {1'b0, req.b};
  assign sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  assign wr.data = sat;
  assign wr.we   = req.vld && req.off_diag && (req.a != '0) && (req.b != '0) &&
                   ((sat < req.cur) || (req.cur == '0));

endmodule

>>> hw/rtl/apsp_checker.sv
module apsp_checker import apsp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [OP_W-1:0]   in_operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] out_distance
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance))
    else $error("stalled result changed");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation == OP_WRITE) |=> out_valid && (out_distance == '0))
    else $error("write transaction gave no zero result");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation == OP_READ) |=> !in_ready)
    else $error("read transaction did not block input");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind all_pairs_shortest_path_top apsp_checker u_apsp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .in_operation (in_bus.operation),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_distance (out_bus.distance)
);
